/* hdl/pidl_pkg.sv */
package pidl_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned PosW        = 7;
  localparam int unsigned KindW       = 2;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned CountOutW   = 7;
  localparam int unsigned DefCapacity = 64;

  // Stream payload widths (padded to whole bytes)
  localparam int unsigned InDataW  = 40;  // position, value
  localparam int unsigned OutDataW = 40;  // read_value, entry_count

  typedef enum logic [KindW-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic [PosW-1:0]         pos;
    logic signed [DataW-1:0] value;
  } cmd_t;

endpackage

/* hdl/pidl_cell.sv */
module pidl_cell #(
  parameter int unsigned CAPACITY = pidl_pkg::DefCapacity,
  parameter int unsigned INDEX    = 0
) (
  input  logic                              clk_i,
  input  pidl_pkg::cmd_t                    cmd_i,
  input  logic signed [pidl_pkg::DataW-1:0] prev_i,  // lower neighbor
  input  logic signed [pidl_pkg::DataW-1:0] next_i,  // upper neighbor
  output logic signed [pidl_pkg::DataW-1:0] data_o,
  output logic signed [pidl_pkg::DataW-1:0] rd_o
);
  import pidl_pkg::*;

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CmpW = (IdxW > PosW) ? IdxW : PosW;
  localparam logic [CmpW-1:0] Idx = CmpW'(INDEX);

  logic signed [DataW-1:0] data_q, data_d;
  logic [CmpW-1:0]         pos;
  logic                    hit, above;

  assign pos   = CmpW'(cmd_i.pos);
  assign hit   = (Idx == pos);
  assign above = (Idx > pos);

  // Shift up on insert, down on delete, else hold
  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (hit) begin
        data_d = cmd_i.value;
      end else if (above) begin
        data_d = prev_i;
      end
    end else if (cmd_i.del && (hit || above)) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = hit ? data_q : '0;

endmodule

/* hdl/positional_insert_delete_list.sv */
// An accepted request has its result registered on the edge that accepts it.
// One request per cycle while the input is not stalled; every cell of the chain shifts in the same cycle.
// The input stalls only while a result waits in the output register and tready is low.
// Reset (rst_ni low, asynchronous) empties the list and drops any pending result;
// cell contents are not cleared, positions at or above the count are never read.
module positional_insert_delete_list #(
  parameter int unsigned CAPACITY = pidl_pkg::DefCapacity
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pidl_pkg::InDataW-1:0]  s_axis_tdata,  // [6:0] position, [38:7] value
  input  logic [pidl_pkg::KindW-1:0]    s_axis_tuser,  // [1:0] kind
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pidl_pkg::OutDataW-1:0] m_axis_tdata,  // [31:0] read_value, [38:32] entry_count
  output logic [pidl_pkg::StatusW-1:0]  m_axis_tuser   // [1:0] status
);
  import pidl_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;
  localparam logic [CmpW-1:0] Full = CmpW'(CAPACITY);

  logic [CntW-1:0]         count_q, count_d;
  logic                    out_valid_q;
  status_e                 status_q, status_d;
  logic signed [DataW-1:0] rdata_q;
  logic [CountOutW-1:0]    ocount_q;

  logic                    accept;
  logic [PosW-1:0]         pos;
  logic signed [DataW-1:0] value;
  logic [CmpW-1:0]         pos_c, cnt_c;
  logic                    ins_ok, del_ok, rd_ok;
  cmd_t                    cmd;

  logic signed [DataW-1:0] cell_data [CAPACITY];
  logic signed [DataW-1:0] cell_rd   [CAPACITY];
  logic [CAPACITY-1:0]     rd_col    [DataW];
  logic signed [DataW-1:0] rd_value;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign pos   = s_axis_tdata[PosW-1:0];
  assign value = s_axis_tdata[PosW+DataW-1:PosW];
  assign pos_c = CmpW'(pos);
  assign cnt_c = CmpW'(count_q);

  // Request decode and range checks
  always_comb begin
    ins_ok   = 1'b0;
    del_ok   = 1'b0;
    rd_ok    = 1'b0;
    status_d = STATUS_RANGE;
    unique case (s_axis_tuser)
      KIND_INSERT: begin
        if (pos_c > cnt_c) begin
          status_d = STATUS_RANGE;
        end else if (cnt_c == Full) begin
          status_d = STATUS_FULL;
        end else begin
          ins_ok   = 1'b1;
          status_d = STATUS_DONE;
        end
      end
      KIND_DELETE: begin
        if (pos_c < cnt_c) begin
          del_ok   = 1'b1;
          status_d = STATUS_DONE;
        end
      end
      KIND_READ: begin
        if (pos_c < cnt_c) begin
          rd_ok    = 1'b1;
          status_d = STATUS_DONE;
        end
      end
      default: status_d = STATUS_RANGE;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + CntW'(1);
    end else if (del_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign cmd.ins   = accept && ins_ok;
  assign cmd.del   = accept && del_ok;
  assign cmd.pos   = pos;
  assign cmd.value = value;

  // Chain of cells, one entry each
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DataW-1:0] prev, next;
    if (g == 0) begin : g_first
      assign prev = value;
    end else begin : g_mid
      assign prev = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next = cell_data[g];
    end else begin : g_up
      assign next = cell_data[g+1];
    end
    pidl_cell #(
      .CAPACITY(CAPACITY),
      .INDEX   (g)
    ) u_cell (
      .clk_i (clk_i),
      .cmd_i (cmd),
      .prev_i(prev),
      .next_i(next),
      .data_o(cell_data[g]),
      .rd_o  (cell_rd[g])
    );
  end

  // Read select: each bit is the OR of the matching cell's contribution
  always_comb begin
    for (int b = 0; b < DataW; b++) begin
      for (int c = 0; c < CAPACITY; c++) begin
        rd_col[b][c] = cell_rd[c][b];
      end
    end
    for (int b = 0; b < DataW; b++) begin
      rd_value[b] = |rd_col[b];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rdata_q  <= rd_ok ? rd_value : '0;
      ocount_q <= CountOutW'(CmpW'(count_d));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {{(OutDataW - DataW - CountOutW){1'b0}}, ocount_q, rdata_q};

endmodule

/* hdl/pidl_checker.sv */
module pidl_checker #(
  parameter int unsigned CAPACITY = pidl_pkg::DefCapacity
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pidl_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [pidl_pkg::StatusW-1:0]  m_axis_tuser
);
  import pidl_pkg::*;

  localparam logic [CountOutW-1:0] FullCnt = CountOutW'(CAPACITY);

  logic [CountOutW-1:0] out_cnt;
  assign out_cnt = m_axis_tdata[DataW+CountOutW-1:DataW];

  // A pending result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // The input never stalls while the output register is empty
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // Full status only when the list holds CAPACITY entries
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STATUS_FULL) |-> out_cnt == FullCnt)
    else $error("full reported with wrong count");

  // Refused requests return zero data
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != STATUS_DONE) |-> m_axis_tdata[DataW-1:0] == '0)
    else $error("refused request returned data");

  // Accepting a request always yields a result on the next cycle
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted request gave no result");

endmodule

bind positional_insert_delete_list pidl_checker #(.CAPACITY(CAPACITY)) u_pidl_checker (.*);

/* tb/positional_insert_delete_list_tb.sv */
`timescale 1ns / 100ps

module positional_insert_delete_list_tb;
  import pidl_pkg::*;

  localparam int unsigned ListCap    = DefCapacity;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold   = 150;
  localparam int unsigned HoldAtResp = 300;
  localparam logic [KindW-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [KindW-1:0]        kind;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] value;
  } list_req_t;

  typedef struct packed {
    status_e                 status;
    logic signed [DataW-1:0] read_value;
    logic [CountOutW-1:0]    entry_count;
  } list_resp_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;   // [6:0] position, [38:7] value
  logic [KindW-1:0]     s_axis_tuser = '0;   // [1:0] kind
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;        // [31:0] read_value, [38:32] entry_count
  logic [StatusW-1:0]   m_axis_tuser;        // [1:0] status

  positional_insert_delete_list u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  list_req_t               pending_q[$];
  list_resp_t              expected_q[$];
  logic signed [DataW-1:0] shadow_list[$];  // predicted list contents, front first
  int unsigned             gen_count;       // entry count as seen by the stimulus generator
  int unsigned             error_cnt = 0;
  int unsigned             resp_cnt = 0;
  int unsigned             cycle_cnt = 0;

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one request to the shadow list and queue its result
  task automatic predict_list_op(input list_req_t req);
    list_resp_t rsp;
    rsp.status      = STATUS_RANGE;
    rsp.read_value  = '0;
    case (req.kind)
      KIND_INSERT: begin
        if (req.position > shadow_list.size()) begin
          rsp.status = STATUS_RANGE;
        end else if (shadow_list.size() >= ListCap) begin
          rsp.status = STATUS_FULL;
        end else begin
          shadow_list.insert(req.position, req.value);
          rsp.status = STATUS_DONE;
        end
      end
      KIND_DELETE: begin
        if (req.position < shadow_list.size()) begin
          shadow_list.delete(req.position);
          rsp.status = STATUS_DONE;
        end
      end
      KIND_READ: begin
        if (req.position < shadow_list.size()) begin
          rsp.read_value = shadow_list[req.position];
          rsp.status     = STATUS_DONE;
        end
      end
      default: ;
    endcase
    rsp.entry_count = CountOutW'(shadow_list.size());
    expected_q.push_back(rsp);
  endtask

  // Queue a request, tracking only the entry count for position choice
  task automatic queue_request(input logic [KindW-1:0] kind, input int unsigned pos,
                               input logic [DataW-1:0] val);
    list_req_t req;
    req.kind     = kind;
    req.position = PosW'(pos);
    req.value    = val;
    pending_q.push_back(req);
    if (kind == KIND_INSERT && pos <= gen_count && gen_count < ListCap) gen_count++;
    else if (kind == KIND_DELETE && pos < gen_count) gen_count--;
  endtask

  // Mostly in-range positions, now and then anything the field holds
  function automatic int unsigned pick_position(input logic [KindW-1:0] kind);
    int unsigned top;
    if ($urandom_range(9) == 0) return $urandom_range(127);
    if (kind == KIND_INSERT) top = gen_count;
    else top = (gen_count == 0) ? 0 : gen_count - 1;
    if (top > 127) top = 127;
    return $urandom_range(top);
  endfunction

  // Stimulus and end of run
  initial begin
    logic [KindW-1:0] kind;
    int unsigned      roll;
    int unsigned      n_items;
    int unsigned      n_total;
    bit               grow;

    gen_count = 0;
    // empty list: everything but insert at the head is refused
    queue_request(KIND_READ,   0,   32'h1234_5678);
    queue_request(KIND_DELETE, 0,   32'h0);
    queue_request(KIND_INSERT, 1,   32'hdead_beef);
    queue_request(KIND_UNUSED, 0,   32'h0);
    // head, tail, middle and front inserts with extreme values
    queue_request(KIND_INSERT, 0,   32'h8000_0000);
    queue_request(KIND_INSERT, 1,   32'h7fff_ffff);
    queue_request(KIND_INSERT, 1,   32'h0000_0000);
    queue_request(KIND_INSERT, 0,   32'hffff_ffff);
    queue_request(KIND_INSERT, 5,   32'h0000_0001);
    for (int i = 0; i < 4; i++) queue_request(KIND_READ, i, 32'h0);
    // reads, a delete and an insert past the end
    queue_request(KIND_READ,   4,   32'h0);
    queue_request(KIND_READ,   127, 32'hffff_ffff);
    queue_request(KIND_DELETE, 127, 32'h0);
    queue_request(KIND_INSERT, 127, 32'h5555_5555);
    // deletes at middle, tail and head
    queue_request(KIND_DELETE, 1,   32'h0);
    queue_request(KIND_DELETE, 2,   32'h0);
    queue_request(KIND_DELETE, 0,   32'h0);
    queue_request(KIND_UNUSED, 127, 32'hffff_ffff);
    queue_request(KIND_READ,   0,   32'h0);

    // random phases alternately fill the list toward full and drain it toward empty
    for (int ph = 0; ph < 4; ph++) begin
      grow    = (ph % 2 == 0);
      n_items = grow ? 165 : 160;
      for (int i = 0; i < n_items; i++) begin
        roll = $urandom_range(99);
        if (grow) kind = (roll < 60) ? KIND_INSERT : (roll < 75) ? KIND_DELETE :
                         (roll < 95) ? KIND_READ : KIND_UNUSED;
        else      kind = (roll < 10) ? KIND_INSERT : (roll < 70) ? KIND_DELETE :
                         (roll < 95) ? KIND_READ : KIND_UNUSED;
        queue_request(kind, pick_position(kind), $urandom);
      end
    end
    n_total = pending_q.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // one result per request
    while (resp_cnt < n_total)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (error_cnt == 0 && expected_q.size() == 0 && !m_axis_tvalid) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Sender: bursts of requests separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  list_req_t   cur_req;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_list_op(cur_req);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(8);
        end
        if (gap_left != 0 || pending_q.size() == 0) begin
          if (gap_left != 0) gap_left--;
          s_axis_tvalid <= 1'b0;
        end else begin
          cur_req = pending_q.pop_front();
          burst_left--;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {1'b0, cur_req.value, cur_req.position};
          s_axis_tuser  <= cur_req.kind;
        end
      end
    end
  end

  // Receiver: changing stall pattern, plus one long hold-off to back up the input
  int unsigned hold_left  = 0;
  int unsigned stall_mode = 0;
  bit          long_done  = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cycle_cnt % 64 == 0) stall_mode = $urandom_range(2);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!long_done && resp_cnt >= HoldAtResp) begin
        long_done = 1'b1;
        hold_left = LongHold;
        m_axis_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(3) != 0);
          default: m_axis_tready <= ($urandom_range(9) < 3);
        endcase
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  list_resp_t exp_rsp;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      resp_cnt++;
      if (expected_q.size() == 0) begin
        error_cnt++;
        $display("%0t: unexpected result status=%0d data=%h", $time, m_axis_tuser,
                 m_axis_tdata);
      end else begin
        exp_rsp = expected_q.pop_front();
        if (m_axis_tuser !== exp_rsp.status) begin
          error_cnt++;
          $display("%0t: status expected %0d actual %0d", $time, exp_rsp.status,
                   m_axis_tuser);
        end
        if (m_axis_tdata[31:0] !== exp_rsp.read_value) begin
          error_cnt++;
          $display("%0t: read_value expected %h actual %h", $time, exp_rsp.read_value,
                   m_axis_tdata[31:0]);
        end
        if (m_axis_tdata[38:32] !== exp_rsp.entry_count) begin
          error_cnt++;
          $display("%0t: entry_count expected %0d actual %0d", $time,
                   exp_rsp.entry_count, m_axis_tdata[38:32]);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

/* positional_insert_delete_list.f */
hdl/pidl_pkg.sv
hdl/pidl_cell.sv
hdl/positional_insert_delete_list.sv
hdl/pidl_checker.sv
tb/positional_insert_delete_list_tb.sv
